// ===== hw/rtl/tcce_pkg.sv =====
// Package with shared types and constants of the text console engine.
package tcce_pkg;

   localparam logic [1:0] OP_PUT  = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_SET  = 2'd2;

   localparam logic [1:0] CSR_COLS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_ATTR = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_UP    = 8'h90;
   localparam logic [7:0] CH_RIGHT = 8'h91;
   localparam logic [7:0] CH_DOWN  = 8'h92;
   localparam logic [7:0] CH_LEFT  = 8'h93;
   localparam logic [7:0] CH_HOME  = 8'h94;
   localparam logic [7:0] CH_DEL   = 8'h99;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [12:0] cell_index;
      logic [5:0]  set_row;
      logic [6:0]  set_col;
   } req_type;

   typedef struct packed {
      logic [5:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [12:0] cursor_address;
      logic [15:0] read_data;
   } rsp_type;

   // Screen code of a byte, without attribute.
   function automatic logic [8:0] to_screen(input logic [7:0] ch);
      logic [8:0] code;
      code = {1'b1, ch};
      if (ch == 8'h5B) code = 9'h01B;
      else if (ch == 8'h5D) code = 9'h01D;
      else if (ch[5] && ch[6]) code = code & 9'h19F;
      return code;
   endfunction

   function automatic logic [15:0] make_cell(input logic [5:0] attr, input logic [7:0] ch);
      return {attr, 1'b0, to_screen(ch)};
   endfunction

endpackage

// ===== hw/rtl/text_console_char_engine_core.sv =====
// Top level of the text console engine: sequencer, shared address adder and screen RAM.
// Row times columns for the cursor address is built by repeated addition, and a tab repeats
// the put. Line shifts move the cells after the cursor one place left and blank the last
// cell of the row, scrolls copy every cell up by a row and blank the bottom row, form feed
// blanks every cell in use; a new word is accepted only after the result word is taken.
// After reset a clearing pass writes zero to every RAM cell
module text_console_char_engine_core #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcce_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcce_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata
);
   import tcce_pkg::*;

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CLAMP = 4'd2;
   localparam logic [3:0] S_DISP  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_RDW   = 4'd5;
   localparam logic [3:0] S_SHRD  = 4'd6;
   localparam logic [3:0] S_SHWR  = 4'd7;
   localparam logic [3:0] S_SCRD  = 4'd8;
   localparam logic [3:0] S_SCWR  = 4'd9;
   localparam logic [3:0] S_FILL  = 4'd10;
   localparam logic [3:0] S_ADDR  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;
   localparam logic [3:0] S_PUT   = 4'd13;

   localparam logic [2:0] J_NONE  = 3'd0;
   localparam logic [2:0] J_SHIFT = 3'd1;
   localparam logic [2:0] J_SCROLL= 3'd2;
   localparam logic [2:0] J_FF    = 3'd3;
   localparam logic [2:0] J_PUT   = 3'd4;
   localparam logic [2:0] J_READ  = 3'd5;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    job_ff, job_in;
   logic [7:0]    cols_reg_ff, cols_reg_in;
   logic [6:0]    rows_reg_ff, rows_reg_in;
   logic [5:0]    attr_ff, attr_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   req_type       req_ff, req_in;
   logic [2:0]    tabs_ff, tabs_in;
   logic [AW:0]   ptr_ff, ptr_in;       // running cell address
   logic [AW:0]   end_ff, end_in;       // stop address
   logic [AW:0]   acc_ff, acc_in;       // row times cols accumulator
   logic [RW-1:0] cnt_ff, cnt_in;
   logic [15:0]   hold_ff, hold_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [CW-1:0] ecols;
   logic [RW-1:0] erows;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic [AW:0]   add_a, add_b, add_y;
   logic [15:0]   blank;

   // Effective geometry, clamped into 1..MAX.
   always_comb begin
      if (cols_reg_ff == 8'd0) ecols = CW'(1);
      else if (32'(cols_reg_ff) > MAX_COLS) ecols = CW'(MAX_COLS);
      else ecols = CW'(cols_reg_ff);
      if (rows_reg_ff == 7'd0) erows = RW'(1);
      else if (32'(rows_reg_ff) > MAX_ROWS) erows = RW'(MAX_ROWS);
      else erows = RW'(rows_reg_ff);
   end

   assign blank = make_cell(attr_ff, CH_SPACE);
   // The one shared adder of the sequencer.
   assign add_y = add_a + add_b;

   tcce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff; job_in = job_ff;
      cols_reg_in = cols_reg_ff; rows_reg_in = rows_reg_ff; attr_in = attr_ff;
      row_in = row_ff; col_in = col_ff; req_in = req_ff; tabs_in = tabs_ff;
      ptr_in = ptr_ff; end_in = end_ff; acc_in = acc_ff; cnt_in = cnt_ff;
      hold_in = hold_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = ptr_ff[AW-1:0]; wr_data = blank;
      rd_addr = ptr_ff[AW-1:0];
      add_a = acc_ff; add_b = (AW+1)'(ecols);

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS: cols_reg_in = csr_wdata;
            CSR_ROWS: rows_reg_in = csr_wdata[6:0];
            CSR_ATTR: attr_in = csr_wdata[5:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_data = '0;
            add_a = ptr_ff; add_b = (AW+1)'(1);
            ptr_in = add_y;
            if (ptr_ff == (AW+1)'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in = req_data; tabs_in = 3'd0; state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (row_ff >= erows) row_in = erows - RW'(1);
            if (col_ff >= ecols) col_in = ecols - CW'(1);
            state_in = S_DISP;
         end
         S_DISP: begin
            job_in = J_NONE;
            state_in = S_ADDR;
            acc_in = '0; cnt_in = '0;
            hold_in = '0;
            unique case (req_ff.op)
               OP_READ: begin
                  job_in = J_READ;
                  ptr_in = (AW+1)'(req_ff.cell_index);
                  rd_addr = AW'(req_ff.cell_index);
                  if (32'(req_ff.cell_index) >= CELLS) job_in = J_NONE;
                  else state_in = S_RDW;
               end
               OP_SET: begin
                  row_in = (RW'(req_ff.set_row) >= erows) ? erows - RW'(1)
                                                          : RW'(req_ff.set_row);
                  col_in = (CW'(req_ff.set_col) >= ecols) ? ecols - CW'(1)
                                                          : CW'(req_ff.set_col);
               end
               OP_PUT: begin
                  priority case (req_ff.char_code)
                     CH_CR: col_in = '0;
                     CH_LF: begin
                        if (row_ff + RW'(1) < erows) row_in = row_ff + RW'(1);
                        else begin job_in = J_SCROLL; state_in = S_MUL; end
                     end
                     CH_RIGHT: if (col_ff + CW'(1) < ecols) col_in = col_ff + CW'(1);
                     CH_UP:    if (row_ff != '0) row_in = row_ff - RW'(1);
                     CH_LEFT:  if (col_ff != '0) col_in = col_ff - CW'(1);
                     CH_DOWN:  if (row_ff + RW'(1) < erows) row_in = row_ff + RW'(1);
                     CH_HOME: begin
                        if (col_ff == '0) row_in = '0;
                        col_in = '0;
                     end
                     CH_DEL: begin job_in = J_SHIFT; state_in = S_MUL; end
                     CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - CW'(1);
                           job_in = J_SHIFT; state_in = S_MUL;
                        end
                     end
                     CH_FF: begin
                        job_in = J_FF; state_in = S_MUL;
                        row_in = '0; col_in = '0;
                     end
                     default: begin
                        job_in = J_PUT; state_in = S_MUL;
                        if (req_ff.char_code == CH_TAB) tabs_in = 3'd3;
                     end
                  endcase
               end
               default: ;
            endcase
         end
         // Multiply by repeated addition: acc = cnt * cols, cnt runs to target row.
         S_MUL: begin
            logic [RW-1:0] target;
            target = (job_ff == J_SCROLL) ? erows - RW'(1)
                   : (job_ff == J_FF) ? erows : row_ff;
            if (cnt_ff == target) begin
               unique case (job_ff)
                  J_SHIFT: begin
                     ptr_in = acc_ff + (AW+1)'(col_ff);
                     end_in = acc_ff + (AW+1)'(ecols) - (AW+1)'(1);
                     state_in = S_SHRD;
                  end
                  J_SCROLL: begin
                     ptr_in = '0; end_in = acc_ff; state_in = S_SCRD;
                  end
                  J_FF: begin
                     ptr_in = '0; end_in = acc_ff; state_in = S_FILL;
                  end
                  default: begin
                     ptr_in = acc_ff + (AW+1)'(col_ff); state_in = S_PUT;
                  end
               endcase
            end else begin
               acc_in = add_y; cnt_in = cnt_ff + RW'(1);
            end
         end
         S_PUT: begin
            wr_en = 1'b1;
            wr_data = make_cell(attr_ff,
                                (req_ff.char_code == CH_TAB) ? CH_SPACE : req_ff.char_code);
            acc_in = '0; cnt_in = '0;
            if (col_ff + CW'(1) >= ecols) begin
               col_in = '0;
               if (row_ff + RW'(1) < erows) begin
                  row_in = row_ff + RW'(1);
                  state_in = (tabs_ff != 3'd0) ? S_MUL : S_ADDR;
               end else begin
                  job_in = J_SCROLL; state_in = S_MUL;
               end
            end else begin
               col_in = col_ff + CW'(1);
               state_in = (tabs_ff != 3'd0) ? S_MUL : S_ADDR;
            end
            // On a scroll the count of spaces left is taken down after the scroll.
            if (tabs_ff != 3'd0 && job_in != J_SCROLL) tabs_in = tabs_ff - 3'd1;
         end
         S_SHRD: begin
            add_a = ptr_ff; add_b = (AW+1)'(1);
            if (ptr_ff == end_ff) begin
               wr_en = 1'b1; wr_data = blank;
               state_in = S_ADDR;
            end else begin
               rd_addr = add_y[AW-1:0];
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_data = rd_data;
            add_a = ptr_ff; add_b = (AW+1)'(1);
            ptr_in = add_y; state_in = S_SHRD;
         end
         S_SCRD: begin
            add_a = ptr_ff; add_b = (AW+1)'(ecols);
            if (ptr_ff == end_ff) begin
               state_in = S_FILL;
               end_in = end_ff + (AW+1)'(ecols);
            end else begin
               rd_addr = add_y[AW-1:0];
               state_in = S_SCWR;
            end
         end
         S_SCWR: begin
            wr_en = 1'b1; wr_data = rd_data;
            add_a = ptr_ff; add_b = (AW+1)'(1);
            ptr_in = add_y; state_in = S_SCRD;
         end
         S_FILL: begin
            add_a = ptr_ff; add_b = (AW+1)'(1);
            if (ptr_ff == end_ff) begin
               acc_in = '0; cnt_in = '0;
               // A wrap scroll inside a tab keeps putting spaces.
               state_in = (job_ff == J_SCROLL && tabs_ff != 3'd0 &&
                           req_ff.char_code == CH_TAB) ? S_MUL : S_ADDR;
               if (state_in == S_MUL) begin
                  job_in = J_PUT;
                  tabs_in = tabs_ff - 3'd1;
               end
            end else begin
               wr_en = 1'b1; wr_data = blank; ptr_in = add_y;
            end
         end
         S_RDW: begin
            hold_in = rd_data; state_in = S_ADDR;
            acc_in = '0; cnt_in = '0;
         end
         S_ADDR: begin
            if (cnt_ff == row_ff) state_in = S_OUT;
            else begin acc_in = add_y; cnt_in = cnt_ff + RW'(1); end
         end
         S_OUT: begin
            rsp_in.cursor_row = row_ff[5:0];
            rsp_in.cursor_col = col_ff[6:0];
            rsp_in.cursor_address = 13'(acc_ff + (AW+1)'(col_ff));
            rsp_in.read_data = (job_ff == J_READ) ? hold_ff : 16'h0000;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; job_ff <= J_NONE;
         cols_reg_ff <= 8'd64; rows_reg_ff <= 7'd32; attr_ff <= 6'd0;
         row_ff <= '0; col_ff <= '0; tabs_ff <= 3'd0;
         ptr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; job_ff <= job_in;
         cols_reg_ff <= cols_reg_in; rows_reg_ff <= rows_reg_in; attr_ff <= attr_in;
         row_ff <= row_in; col_ff <= col_in; tabs_ff <= tabs_in;
         ptr_ff <= ptr_in; rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in; end_ff <= end_in; acc_ff <= acc_in; cnt_ff <= cnt_in;
      hold_ff <= hold_in; rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("accept with result pending");
`endif
endmodule

// ===== hw/rtl/tcce_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== verif/text_console_char_engine_core_checker.sv =====
// Checker for the text console engine: shadow screen, cursor prediction and result compare.
module text_console_char_engine_core_checker #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tcce_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcce_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                pending
);
   import tcce_pkg::*;

   localparam int CELLS = MAX_COLS * MAX_ROWS;

   logic [15:0] shadow_screen [CELLS];
   int          crow, ccol;
   logic [7:0]  cols_reg;
   logic [6:0]  rows_reg;
   logic [5:0]  attr_reg;
   rsp_type     expected_words [$];

   function automatic int cols_in_use();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
   endfunction

   function automatic int rows_in_use();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
   endfunction

   function automatic logic [15:0] cell_of(input logic [7:0] ch);
      logic [8:0] code;
      if (ch == 8'h5B) code = 9'h01B;
      else if (ch == 8'h5D) code = 9'h01D;
      else begin
         code = {1'b1, ch};
         if (ch[5] && ch[6]) code = code & 9'h19F;
      end
      return {attr_reg, 1'b0, code};
   endfunction

   task automatic line_feed();
      int cols, rows;
      cols = cols_in_use();
      rows = rows_in_use();
      if (crow + 1 < rows) begin
         crow++;
      end else begin
         for (int i = 0; i < (rows - 1) * cols; i++) shadow_screen[i] = shadow_screen[i + cols];
         for (int c = 0; c < cols; c++) shadow_screen[(rows - 1) * cols + c] = cell_of(CH_SPACE);
      end
   endtask

   task automatic write_glyph(input logic [7:0] ch);
      int cols;
      cols = cols_in_use();
      shadow_screen[crow * cols + ccol] = cell_of(ch);
      ccol++;
      if (ccol >= cols) begin
         ccol = 0;
         line_feed();
      end
   endtask

   task automatic close_gap();
      int cols, base;
      cols = cols_in_use();
      base = crow * cols;
      for (int n = ccol; n + 1 < cols; n++) shadow_screen[base + n] = shadow_screen[base + n + 1];
      shadow_screen[base + cols - 1] = cell_of(CH_SPACE);
   endtask

   task automatic apply_char(input logic [7:0] ch);
      int cols, rows;
      cols = cols_in_use();
      rows = rows_in_use();
      case (ch)
         CH_CR:    ccol = 0;
         CH_LF:    line_feed();
         CH_RIGHT: if (ccol + 1 < cols) ccol++;
         CH_UP:    if (crow > 0) crow--;
         CH_LEFT:  if (ccol > 0) ccol--;
         CH_DOWN:  if (crow + 1 < rows) crow++;
         CH_HOME: begin
            if (ccol == 0) crow = 0;
            ccol = 0;
         end
         CH_DEL:   close_gap();
         CH_BS: begin
            if (ccol > 0) begin
               ccol--;
               close_gap();
            end
         end
         CH_FF: begin
            for (int i = 0; i < rows * cols; i++) shadow_screen[i] = cell_of(CH_SPACE);
            crow = 0;
            ccol = 0;
         end
         CH_TAB:   repeat (4) write_glyph(CH_SPACE);
         default:  write_glyph(ch);
      endcase
   endtask

   task automatic predict_word(input req_type w);
      int cols, rows;
      rsp_type e;
      cols = cols_in_use();
      rows = rows_in_use();
      if (crow >= rows) crow = rows - 1;
      if (ccol >= cols) ccol = cols - 1;
      e.read_data = '0;
      case (w.op)
         OP_PUT:  apply_char(w.char_code);
         OP_READ: if (w.cell_index < CELLS) e.read_data = shadow_screen[w.cell_index];
         OP_SET: begin
            crow = (w.set_row >= rows) ? rows - 1 : w.set_row;
            ccol = (w.set_col >= cols) ? cols - 1 : w.set_col;
         end
         default: ;
      endcase
      e.cursor_row     = crow[5:0];
      e.cursor_col     = ccol[6:0];
      e.cursor_address = 13'(crow * cols + ccol);
      expected_words.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
         crow = 0;
         ccol = 0;
         cols_reg = 8'd64;
         rows_reg = 7'd32;
         attr_reg = '0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLS: cols_reg = csr_wdata;
               CSR_ROWS: rows_reg = csr_wdata[6:0];
               CSR_ATTR: attr_reg = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result word %h", rsp_data);
            end else begin
               e = expected_words.pop_front();
               if (e !== rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: row %0d/%0d col %0d/%0d addr %0d/%0d data %h/%h (exp/act)",
                        e.cursor_row, rsp_data.cursor_row, e.cursor_col, rsp_data.cursor_col,
                        e.cursor_address, rsp_data.cursor_address,
                        e.read_data, rsp_data.read_data);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== verif/text_console_char_engine_core_test.sv =====
// Testbench top for the text console engine: stimulus, configuration phases and verdict.
module text_console_char_engine_core_test;
   import tcce_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   int      fail_count, pending;

   bit      no_gaps = 0;
   bit      hold_output = 0;
   int      idle_cycles = 0;
   int      words_sent = 0;
   int      settings_used = 1;
   int      area_cols = 64, area_rows = 32;

   localparam logic [7:0] CONTROLS [12] = '{CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR, CH_UP,
      CH_RIGHT, CH_DOWN, CH_LEFT, CH_HOME, CH_DEL, 8'h5B};

   always #5 clock = ~clock;

   text_console_char_engine_core DUT (.*);
   text_console_char_engine_core_checker CHK (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Output side: short random stalls, now and then a long one, and one forced hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_output = 0;
         end else if (!no_gaps && $urandom_range(0, 299) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(30, 80)) @(negedge clock);
         end else begin
            rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 30);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 100000) begin
         $display("watchdog expired with %0d words outstanding", pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_word(input req_type w);
      repeat (pick_gap()) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic put_op(input logic [1:0] op, input logic [7:0] ch, input int idx,
                         input int r, input int c);
      req_type w;
      w.op = op;
      w.char_code = ch;
      w.cell_index = 13'(idx);
      w.set_row = 6'(r);
      w.set_col = 7'(c);
      send_word(w);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input int cols, input int rows, input int attr);
      drain();
      write_reg(CSR_COLS, 8'(cols));
      write_reg(CSR_ROWS, 8'(rows));
      write_reg(CSR_ATTR, 8'(attr));
      area_cols = (cols == 0) ? 1 : (cols > 128 ? 128 : cols);
      area_rows = (rows == 0) ? 1 : (rows > 64 ? 64 : rows);
      settings_used++;
   endtask

   task automatic random_word();
      req_type w;
      int r;
      w = req_type'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 55) w.op = OP_PUT;
      else if (r < 75) w.op = OP_READ;
      else if (r < 94) w.op = OP_SET;
      else w.op = 2'd3;
      if ($urandom_range(0, 99) < 30) w.char_code = CONTROLS[$urandom_range(0, 11)];
      // Form feed and line feed on a big screen are slow, so keep them rare there.
      if (area_cols * area_rows > 2048 && (w.char_code == CH_FF || w.char_code == CH_LF)
          && $urandom_range(0, 9) != 0)
         w.char_code = 8'h41;
      if ($urandom_range(0, 99) < 70)
         w.cell_index = 13'($urandom_range(0, area_cols * area_rows - 1));
      if ($urandom_range(0, 1)) begin
         w.set_row = 6'($urandom_range(0, area_rows - 1));
         w.set_col = 7'($urandom_range(0, area_cols - 1));
      end
      send_word(w);
   endtask

   initial begin
      int pcols [9] = '{8, 1, 0, 255, 16, 5, 128, 40, 3};
      int prows [9] = '{4, 1, 0, 127, 8, 3, 64, 16, 2};
      int pattr [9] = '{63, 0, 21, 42, 7, 56, 63, 0, 33};
      int pnum  [9] = '{320, 120, 80, 30, 330, 320, 30, 300, 300};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part at the reset geometry of 64 by 32.
      put_op(OP_READ, 8'h00, 5, 0, 0);
      put_op(OP_PUT, 8'h41, 0, 0, 0);
      put_op(OP_PUT, 8'h5B, 0, 0, 0);
      put_op(OP_PUT, 8'h5D, 0, 0, 0);
      put_op(OP_PUT, 8'h60, 0, 0, 0);
      put_op(OP_PUT, 8'hFF, 0, 0, 0);
      put_op(OP_PUT, 8'h00, 0, 0, 0);
      put_op(OP_PUT, CH_TAB, 0, 0, 0);
      put_op(OP_PUT, CH_LEFT, 0, 0, 0);
      put_op(OP_PUT, CH_BS, 0, 0, 0);
      put_op(OP_PUT, CH_DEL, 0, 0, 0);
      put_op(OP_PUT, CH_RIGHT, 0, 0, 0);
      put_op(OP_PUT, CH_DOWN, 0, 0, 0);
      put_op(OP_PUT, CH_UP, 0, 0, 0);
      put_op(OP_PUT, CH_UP, 0, 0, 0);
      put_op(OP_PUT, CH_HOME, 0, 0, 0);
      put_op(OP_PUT, CH_BS, 0, 0, 0);
      put_op(OP_SET, 8'h00, 0, 63, 127);
      put_op(OP_PUT, 8'h7A, 0, 0, 0);
      put_op(OP_SET, 8'h00, 0, 31, 5);
      put_op(OP_PUT, CH_LF, 0, 0, 0);
      put_op(OP_PUT, CH_CR, 0, 0, 0);
      put_op(2'd3, 8'hFF, 8191, 63, 127);
      put_op(OP_READ, 8'h00, 8191, 0, 0);
      put_op(OP_READ, 8'h00, 30 * 64 + 5, 0, 0);
      put_op(OP_PUT, CH_FF, 0, 0, 0);
      put_op(OP_PUT, CH_HOME, 0, 0, 0);

      for (int p = 0; p < 9; p++) begin
         configure(pcols[p], prows[p], pattr[p]);
         no_gaps = (p % 3 == 2);
         for (int i = 0; i < pnum[p]; i++) begin
            if (p == 4 && i == 20) hold_output = 1;
            random_word();
         end
      end

      drain();
      $display("sent %0d words over %0d screen geometries and attributes", words_sent,
               settings_used);
      $display("covered controls, scrolls, clears, reads and cursor saturation");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== text_console_char_engine_core.f =====
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/text_console_char_engine_core.sv
verif/text_console_char_engine_core_checker.sv
verif/text_console_char_engine_core_test.sv
